// ===== src/wpm_pkg.sv =====
// ----------------------------------------------------------------------------
// wpm_pkg
// Shared types and constants for the wildcard pattern matcher: request
// opcodes, sequencer states and the wildcard byte codes.
// ----------------------------------------------------------------------------
package wpm_pkg;

    // Request opcodes.
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_TEXT   = 2'd2,
        OP_REPORT = 2'd3
    } op_t;

    // Sequencer states.
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_WALK = 1'b1
    } state_t;

    // Wildcard bytes of the pattern.
    localparam logic [7:0] STAR_BYTE = 8'h2A;
    localparam logic [7:0] ANY_BYTE  = 8'h3F;

    // One pattern RAM word holds a pattern byte and the match bit of the
    // prefix that ends with that byte.
    localparam int CH_W   = 8;
    localparam int WORD_W = CH_W + 1;

endpackage

// ===== src/wpm_in_if.sv =====
// ----------------------------------------------------------------------------
// wpm_in_if
// Request channel of the wildcard pattern matcher: opcode and byte.
// ----------------------------------------------------------------------------
interface wpm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] ch;

    modport source (output valid, output op, output ch, input ready);
    modport sink   (input valid, input op, input ch, output ready);
endinterface

// ===== src/wpm_out_if.sv =====
// ----------------------------------------------------------------------------
// wpm_out_if
// Response channel of the wildcard pattern matcher: match and overflow flags.
// ----------------------------------------------------------------------------
interface wpm_out_if;
    logic valid;
    logic ready;
    logic matched;
    logic pattern_overflowed;

    modport source (output valid, output matched, output pattern_overflowed, input ready);
    modport sink   (input valid, input matched, input pattern_overflowed, output ready);
endinterface

// ===== src/wpm_ram.sv =====
// ----------------------------------------------------------------------------
// wpm_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module wpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/wildcard_pattern_matcher.sv =====
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher
// Whole-string wildcard match of a stored byte pattern against a text fed
// one byte at a time.
// ----------------------------------------------------------------------------
// A text byte walks the pattern RAM one position per cycle through its
// single read port, and each position's new match bit is written back the
// cycle after its read, so the walk is a read-modify-write pipeline over the
// RAM. An empty pattern makes a text byte skip the walk. No clearing pass
// follows reset. The pattern and the per-prefix match bits share one RAM
// word per pattern position; after any text restart the stored match bits
// are ignored and the row is taken from the count of leading stars until
// the next text byte rewrites it. A report request needs the response
// register free and answers on the next cycle. While a response waits for
// the receiver, no request of any kind is taken, so every request stalls
// for as long as the receiver holds off.
// ----------------------------------------------------------------------------
module wildcard_pattern_matcher
    import wpm_pkg::*;
#(
    parameter int MAX_PATTERN = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    wpm_in_if.sink    cmd,
    wpm_out_if.source rsp
);

    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    // Control state.
    state_t        state_reg, state_next;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] lead_reg, lead_next;
    logic          ovf_reg, ovf_next;
    logic          fresh_reg, fresh_next;
    logic          final_reg, final_next;
    logic          new_prev_reg, new_prev_next;
    logic          old_prev_reg, old_prev_next;
    logic          rsp_valid_reg, rsp_valid_next;

    // Payload state.
    logic [IW-1:0]   idx_reg, idx_next;
    logic [CH_W-1:0] ch_reg, ch_next;
    logic            matched_reg, matched_next;
    logic            rsp_ovf_reg, rsp_ovf_next;

    // Pattern RAM port signals.
    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [IW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    // Walk datapath.
    logic            cmd_ready;
    logic            accept;
    logic [LW-1:0]   idx_ext;
    logic [CH_W-1:0] pat_byte;
    logic            old_here;
    logic            bit_next;
    logic            walk_last;

    wpm_ram #(
        .WIDTH(WORD_W),
        .DEPTH(MAX_PATTERN)
    ) u_pattern_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Handshake.
    assign cmd_ready   = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign accept      = cmd.valid && cmd_ready;
    assign cmd.ready   = cmd_ready;
    assign rsp.valid   = rsp_valid_reg;
    assign rsp.matched = matched_reg;
    assign rsp.pattern_overflowed = rsp_ovf_reg;

    // Match bit update for the position whose RAM word arrives this cycle.
    // Right after a restart the old bit of prefix k is set only when the
    // first k pattern bytes are all stars.
    always_comb
    begin
        idx_ext   = LW'(idx_reg);
        pat_byte  = ram_rdata[WORD_W-1:1];
        old_here  = fresh_reg ? (idx_ext < lead_reg) : ram_rdata[0];
        walk_last = ((idx_ext + LW'(1)) == len_reg);
        if (pat_byte == STAR_BYTE)
        begin
            bit_next = new_prev_reg || old_here;
        end
        else if ((pat_byte == ANY_BYTE) || (pat_byte == ch_reg))
        begin
            bit_next = old_prev_reg;
        end
        else
        begin
            bit_next = 1'b0;
        end
    end

    // Next state, RAM control and response.
    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        lead_next      = lead_reg;
        ovf_next       = ovf_reg;
        fresh_next     = fresh_reg;
        final_next     = final_reg;
        new_prev_next  = new_prev_reg;
        old_prev_next  = old_prev_reg;
        rsp_valid_next = rsp_valid_reg;
        idx_next       = idx_reg;
        ch_next        = ch_reg;
        matched_next   = matched_reg;
        rsp_ovf_next   = rsp_ovf_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg;
        ram_wdata      = {pat_byte, bit_next};
        ram_re         = 1'b0;
        ram_raddr      = '0;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (op_t'(cmd.op))
                        OP_CLEAR:
                        begin
                            len_next   = '0;
                            lead_next  = '0;
                            ovf_next   = 1'b0;
                            fresh_next = 1'b1;
                        end
                        OP_APPEND:
                        begin
                            if (len_reg < LW'(MAX_PATTERN))
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = len_reg[IW-1:0];
                                ram_wdata = {cmd.ch, 1'b0};
                                len_next  = len_reg + LW'(1);
                                if ((cmd.ch == STAR_BYTE) && (lead_reg == len_reg))
                                begin
                                    lead_next = lead_reg + LW'(1);
                                end
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                            fresh_next = 1'b1;
                        end
                        OP_TEXT:
                        begin
                            if (len_reg == '0)
                            begin
                                // Empty pattern: only the empty prefix exists, now unmatched.
                                fresh_next = 1'b0;
                                final_next = 1'b0;
                            end
                            else
                            begin
                                ram_re        = 1'b1;
                                ram_raddr     = '0;
                                idx_next      = '0;
                                ch_next       = cmd.ch;
                                new_prev_next = 1'b0;
                                old_prev_next = fresh_reg;
                                state_next    = ST_WALK;
                            end
                        end
                        OP_REPORT:
                        begin
                            rsp_valid_next = 1'b1;
                            matched_next   = fresh_reg ? (lead_reg == len_reg) : final_reg;
                            rsp_ovf_next   = ovf_reg;
                            fresh_next     = 1'b1;
                        end
                        default:
                        begin
                            fresh_next = fresh_reg;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                // Write back this position while the next one is read; the
                // two addresses always differ, so no forwarding is needed.
                ram_we        = 1'b1;
                new_prev_next = bit_next;
                old_prev_next = old_here;
                if (walk_last)
                begin
                    final_next = bit_next;
                    fresh_next = 1'b0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = IW'(idx_ext + LW'(1));
                    idx_next  = IW'(idx_ext + LW'(1));
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            lead_reg      <= '0;
            ovf_reg       <= 1'b0;
            fresh_reg     <= 1'b1;
            final_reg     <= 1'b0;
            new_prev_reg  <= 1'b0;
            old_prev_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            lead_reg      <= lead_next;
            ovf_reg       <= ovf_next;
            fresh_reg     <= fresh_next;
            final_reg     <= final_next;
            new_prev_reg  <= new_prev_next;
            old_prev_reg  <= old_prev_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        ch_reg      <= ch_next;
        matched_reg <= matched_next;
        rsp_ovf_reg <= rsp_ovf_next;
    end

`ifndef SYNTH
    // A walk only runs over a non-empty pattern.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (len_reg != '0))
        else $error("walk over an empty pattern");

    // The walk index stays inside the stored pattern.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (LW'(idx_reg) < len_reg))
        else $error("walk index beyond pattern length");

    // The leading star count never exceeds the pattern length, nor the length MAX_PATTERN.
    assert property (@(posedge clk) disable iff (!rst_n)
        (lead_reg <= len_reg) && (len_reg <= LW'(MAX_PATTERN)))
        else $error("pattern length bookkeeping broken");

    // An accepted report request shows a response on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op_t'(cmd.op) == OP_REPORT)) |=> rsp_valid_reg)
        else $error("report request without response");

    // No request is taken while a walk is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> !cmd_ready)
        else $error("request taken during walk");
`endif

endmodule
